[src/imu_unp_pkg.sv]
// Shared types and constants for the IMU FIFO motion sample unpacker.
package imu_unp_pkg;

	// Field widths are fixed by the FIFO entry format
	localparam int AXIS_WIDTH  = 16;
	localparam int MAG_WIDTH   = 16;
	localparam int TAG_WIDTH   = 5;
	localparam int SUM_WIDTH   = 32;   // 3 * 32768^2 fits
	localparam int ROOT_WIDTH  = 16;
	localparam int PROD_WIDTH  = 27;   // 56755 * 1953 < 2^27
	localparam int RECIP_SHIFT = 37;
	localparam int RECIP_WIDTH = 28;
	localparam int QPROD_WIDTH = PROD_WIDTH + RECIP_WIDTH;
	localparam int QUOT_WIDTH  = QPROD_WIDTH - RECIP_SHIFT;

	localparam logic [TAG_WIDTH-1:0]   TAG_GYRO    = 5'h01;
	localparam logic [TAG_WIDTH-1:0]   TAG_HIGHG   = 5'h1D;
	localparam logic [MAG_WIDTH-1:0]   DEFAULT_MAG = 16'd1000;
	localparam logic [10:0]            SCALE_NUM   = 11'd1953;
	// ceil(2^37 / 1000): exact floor division for any product below 2^27
	localparam logic [RECIP_WIDTH-1:0] RECIP_MULT  = 28'd137438954;
	localparam logic [SUM_WIDTH-1:0]   ROOT_BIT0   = 32'h4000_0000;

	// Register index, taken from paddr[2]
	localparam logic REG_SENSOR_READY = 1'b0;

	typedef struct packed {
		logic                         entry_present;
		logic [7:0]                   tag_byte;
		logic signed [AXIS_WIDTH-1:0] axis_x;
		logic signed [AXIS_WIDTH-1:0] axis_y;
		logic signed [AXIS_WIDTH-1:0] axis_z;
		logic                         batch_last;
	} imu_entry_t;

	typedef struct packed {
		logic [MAG_WIDTH-1:0] accel_magnitude_mg;
		logic                 accel_seen;
		logic signed [15:0]   gyro_x;
		logic signed [15:0]   gyro_y;
		logic signed [15:0]   gyro_z;
	} imu_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SQUARE,
		ST_ROOT_LOAD,
		ST_ROOT,
		ST_SCALE,
		ST_RECIP,
		ST_EMIT
	} unp_state_t;

	typedef struct packed {
		logic load_item;
		logic gyro_load;
		logic sq_start;
		logic sq_step;
		logic root_start;
		logic root_step;
		logic scale;
		logic recip;
		logic store_mag;
		logic emit;
	} unp_cmd_t;

	typedef struct packed {
		logic is_gyro;
		logic is_accel;
		logic is_last;
		logic sq_done;
		logic root_done;
		logic out_free;
	} unp_status_t;

endpackage

[src/imu_unp_ctrl.sv]
// Sequencing state machine for the unpacker.
module imu_unp_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    entry_valid,
	input  imu_unp_pkg::unp_status_t status,
	output imu_unp_pkg::unp_cmd_t   cmd,
	output logic                    entry_stall
);
	import imu_unp_pkg::*;

	unp_state_t state_q, state_d;
	logic       last_q;   // remembers batch_last across the magnitude pass

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECODE) begin
				last_q <= status.is_last;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (entry_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				priority if (status.is_accel) state_d = ST_SQUARE;
				else if (status.is_last)      state_d = ST_EMIT;
				else                          state_d = ST_IDLE;
			end
			ST_SQUARE: begin
				if (status.sq_done) state_d = ST_ROOT_LOAD;
			end
			ST_ROOT_LOAD: state_d = ST_ROOT;
			ST_ROOT: begin
				if (status.root_done) state_d = ST_SCALE;
			end
			ST_SCALE: state_d = ST_RECIP;
			ST_RECIP: state_d = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		entry_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				entry_stall   = 1'b0;
				cmd.load_item = entry_valid;
			end
			ST_DECODE: begin
				cmd.gyro_load = status.is_gyro;
				cmd.sq_start  = status.is_accel;
			end
			ST_SQUARE:    cmd.sq_step    = 1'b1;
			ST_ROOT_LOAD: cmd.root_start = 1'b1;
			ST_ROOT:      cmd.root_step  = 1'b1;
			ST_SCALE:     cmd.scale      = 1'b1;
			ST_RECIP:     cmd.recip      = 1'b1;
			ST_EMIT:      cmd.emit       = status.out_free;
			default: cmd = '0;
		endcase
	end

	// magnitude is written back in the cycle after the reciprocal multiply
	// (the write is enabled by store_q, the registered recip command in the datapath)

endmodule

[src/imu_unp_dp.sv]
// Datapath: entry register, held state, square/root/scale units, result register.
module imu_unp_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sensor_ready,
	input  imu_unp_pkg::imu_entry_t  entry_data,
	input  imu_unp_pkg::unp_cmd_t    cmd,
	output imu_unp_pkg::unp_status_t status,
	output logic                     result_valid,
	input  logic                     result_stall,
	output imu_unp_pkg::imu_result_t result_data
);
	import imu_unp_pkg::*;

	imu_entry_t                  item_q;
	logic signed [15:0]          gyro_x_q, gyro_y_q, gyro_z_q;
	logic [MAG_WIDTH-1:0]        mag_q;
	logic                        accel_q;
	logic [1:0]                  sel_q;
	logic [SUM_WIDTH-1:0]        acc_q;
	logic [SUM_WIDTH-1:0]        rem_q, root_q, bit_q;
	logic [PROD_WIDTH-1:0]       prod_q;
	logic [QPROD_WIDTH-1:0]      qprod_q;
	logic                        store_q;
	imu_result_t                 result_q;
	logic                        result_valid_q;

	logic [TAG_WIDTH-1:0]        tag;
	logic [AXIS_WIDTH-1:0]       axis_sel, axis_abs;
	logic [SUM_WIDTH:0]          trial;
	logic [QUOT_WIDTH-1:0]       quot;
	logic [MAG_WIDTH-1:0]        mag_sat;
	logic                        out_free;

	assign tag = item_q.tag_byte[7:3];

	always_comb begin
		unique case (sel_q)
			2'd0:    axis_sel = item_q.axis_x;
			2'd1:    axis_sel = item_q.axis_y;
			default: axis_sel = item_q.axis_z;
		endcase
		// two's complement magnitude; the most negative value maps to 2^(W-1)
		axis_abs = axis_sel[AXIS_WIDTH-1] ? (~axis_sel + 1'b1) : axis_sel;
	end

	assign trial   = {1'b0, root_q} + {1'b0, bit_q};
	assign quot    = qprod_q[QPROD_WIDTH-1:RECIP_SHIFT];
	assign mag_sat = (|quot[QUOT_WIDTH-1:MAG_WIDTH]) ? {MAG_WIDTH{1'b1}} : quot[MAG_WIDTH-1:0];
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		status.is_gyro   = sensor_ready && item_q.entry_present && (tag == TAG_GYRO);
		status.is_accel  = sensor_ready && item_q.entry_present && (tag == TAG_HIGHG);
		status.is_last   = item_q.batch_last;
		status.sq_done   = (sel_q == 2'd2);
		status.root_done = bit_q[0];
		status.out_free  = out_free;
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= entry_data;
		if (cmd.sq_start) begin
			sel_q <= 2'd0;
			acc_q <= '0;
		end else if (cmd.sq_step) begin
			sel_q <= sel_q + 2'd1;
			acc_q <= acc_q + SUM_WIDTH'(axis_abs * axis_abs);
		end
		if (cmd.root_start) begin
			rem_q  <= acc_q;
			root_q <= '0;
			bit_q  <= ROOT_BIT0;
		end else if (cmd.root_step) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q  <= rem_q - trial[SUM_WIDTH-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.scale) prod_q  <= PROD_WIDTH'(root_q[ROOT_WIDTH-1:0] * SCALE_NUM);
		if (cmd.recip) qprod_q <= prod_q * RECIP_MULT;
		if (cmd.emit) begin
			if (sensor_ready) begin
				// a magnitude still on its way to mag_q is taken straight from the scaler
				result_q.accel_magnitude_mg <= store_q ? mag_sat :
					(accel_q ? mag_q : DEFAULT_MAG);
				result_q.accel_seen         <= store_q || accel_q;
				result_q.gyro_x             <= gyro_x_q;
				result_q.gyro_y             <= gyro_y_q;
				result_q.gyro_z             <= gyro_z_q;
			end else begin
				result_q.accel_magnitude_mg <= DEFAULT_MAG;
				result_q.accel_seen         <= 1'b0;
				result_q.gyro_x             <= '0;
				result_q.gyro_y             <= '0;
				result_q.gyro_z             <= '0;
			end
		end
	end

	// held batch state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_x_q       <= '0;
			gyro_y_q       <= '0;
			gyro_z_q       <= '0;
			mag_q          <= DEFAULT_MAG;
			accel_q        <= 1'b0;
			store_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			store_q <= cmd.recip;
			if (cmd.emit) begin
				gyro_x_q <= '0;
				gyro_y_q <= '0;
				gyro_z_q <= '0;
				mag_q    <= DEFAULT_MAG;
				accel_q  <= 1'b0;
			end else begin
				if (cmd.gyro_load) begin
					gyro_x_q <= item_q.axis_x;
					gyro_y_q <= item_q.axis_y;
					gyro_z_q <= item_q.axis_z;
				end
				if (store_q || cmd.store_mag) begin
					mag_q   <= mag_sat;
					accel_q <= 1'b1;
				end
			end
			if (cmd.emit)          result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

[src/imu_fifo_motion_sample_unpacker.sv]
// Top level of the IMU FIFO motion sample unpacker: APB register, controller, datapath.
//
//  port group   dir  handshake               payload
//  entry        in   entry_valid/entry_stall  imu_entry_t  (tag byte, three axes, last mark)
//  result       out  result_valid/result_stall imu_result_t (magnitude mg, seen flag, gyro)
//  apb          in   psel/penable/pready      sensor_ready at byte address 0
//
// A gyro or ignored word is accepted and decoded; a high-g accel word is accepted, decoded,
// then goes through 3 squares on one 16x16 multiplier, root load, 16 root steps, scale and
// reciprocal divide. A last word adds an emit step, and the magnitude write-back (or the
// emit bypass) falls in the cycle after the reciprocal multiply.
// Reset: gyro axes 0, magnitude 1000, seen flag and sensor_ready 0; no clearing pass.
// Stalls: result register holds under result_stall; a last word waits in emit until it frees.
module imu_fifo_motion_sample_unpacker (
	input  logic                     clk,
	input  logic                     arst_n,
	// entry channel
	input  logic                     entry_valid,
	output logic                     entry_stall,
	input  imu_unp_pkg::imu_entry_t  entry_data,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output imu_unp_pkg::imu_result_t result_data,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import imu_unp_pkg::*;

	logic        sensor_ready_q;
	logic        reg_write;
	unp_cmd_t    cmd;
	unp_status_t status;

	// APB: zero wait states, one register
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && (paddr[2] == REG_SENSOR_READY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_ready_q <= 1'b0;
		end else if (reg_write) begin
			sensor_ready_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SENSOR_READY) begin
			prdata[0] = sensor_ready_q;
		end
	end

	imu_unp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.status      (status),
		.cmd         (cmd),
		.entry_stall (entry_stall)
	);

	imu_unp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sensor_ready (sensor_ready_q),
		.entry_data   (entry_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// emit is only issued into a free result register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("emit issued while result register occupied");

	// sensor not ready gives the default result
	a_default_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && !sensor_ready_q |=> result_valid &&
			result_data.accel_magnitude_mg == DEFAULT_MAG && !result_data.accel_seen &&
			result_data.gyro_x == '0 && result_data.gyro_y == '0 && result_data.gyro_z == '0)
		else $error("non-default result with sensor not ready");

	// without an accel word the magnitude is the default
	a_unseen_default: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.accel_seen |->
			result_data.accel_magnitude_mg == DEFAULT_MAG)
		else $error("magnitude set without accel word");

endmodule
